[src/sact_pkg.sv]
// Package for the set-associative cache tag lookup block.
// Shared constants and types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sact_pkg;
    localparam int NUM_SETS   = 64;
    localparam int MAX_WAYS   = 8;
    localparam int TAG_BITS   = 20;
    localparam int STAMP_BITS = 32;
    localparam int SET_BITS   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_BITS   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_BITS  = 4;
    localparam int LINE_BITS  = 2 + TAG_BITS + STAMP_BITS;
    localparam int SET_WORD   = MAX_WAYS * LINE_BITS;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPLACE_MODE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WAYS_IN_USE  = 1'd1;
    localparam logic MODE_LRU = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic                  dirty;
        logic [TAG_BITS-1:0]   tag;
        logic [STAMP_BITS-1:0] stamp;
    } t_line;

    typedef struct packed {
        logic                is_write;
        logic [SET_BITS-1:0] set_index;
        logic [TAG_BITS-1:0] tag;
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_bk_state;
endpackage
`default_nettype wire

[src/sact_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[src/sact_front.sv]
// Front end: accepts request beats and queues them for the back end.
// Depends on sact_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sact_front
    import sact_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_func,
    input  wire logic [5:0]          i_set_index,
    input  wire logic [TAG_BITS-1:0] i_addr_tag,
    output logic                     o_q_valid,
    input  wire logic                i_q_pop,
    output t_req                     o_q_req
);
    // two-entry queue
    t_req       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       push;
    t_req       req;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rd];

    // classify: set index folded to the set count, kind decoded
    always_comb begin
        req.is_write  = (i_func == FUNC_WRITE);
        req.set_index = SET_BITS'(32'(i_set_index) % NUM_SETS);
        req.tag       = i_addr_tag;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= req;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (i_q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> o_stall) else $error("full queue not stalled");
endmodule
`default_nettype wire

[src/sact_back.sv]
// Back end: reads a set, compares ways, picks victim, writes set back.
// Depends on sact_pkg and sact_ram.
`timescale 1ns / 1ps
`default_nettype none
module sact_back
    import sact_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_mode,
    input  wire logic [WCNT_BITS-1:0] i_ways,
    input  wire logic                 i_q_valid,
    output logic                      o_q_pop,
    input  wire t_req                 i_q_req,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_hit,
    output logic [2:0]                o_way_used,
    output logic                      o_write_back,
    output logic [TAG_BITS-1:0]       o_victim_tag
);
    t_bk_state r_state, n_state;
    t_req      r_req;
    logic [STAMP_BITS-1:0] r_count;
    logic [NUM_SETS-1:0]   r_set_init;   // set ever written; else reads as empty
    logic [SET_WORD-1:0]   rdata, wdata;
    logic [SET_BITS-1:0]   raddr;
    logic                  we;
    logic                  r_ovalid;
    logic                  r_hit, r_wb;
    logic [WAY_BITS-1:0]   r_way;
    logic [TAG_BITS-1:0]   r_vtag;

    // read the queue head while idle, then hold the set of the beat in flight
    assign raddr = (r_state == ST_IDLE) ? i_q_req.set_index : r_req.set_index;

    sact_ram #(.WIDTH(SET_WORD), .DEPTH(NUM_SETS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_req.set_index),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // active way count, clamped to 1..MAX_WAYS
    logic [WCNT_BITS:0] ways;
    always_comb begin
        ways = {1'b0, i_ways};
        if (ways == '0) ways = (WCNT_BITS+1)'(1);
        if (ways > (WCNT_BITS+1)'(MAX_WAYS)) ways = (WCNT_BITS+1)'(MAX_WAYS);
    end

    // compare the active ways in parallel, pick victim
    t_line               lines [MAX_WAYS];
    logic [STAMP_BITS-1:0] stamp;
    logic                hit, found, wb;
    logic [WAY_BITS-1:0] hway, vway, way;
    logic [STAMP_BITS-1:0] oldest;
    always_comb begin
        stamp = r_count + STAMP_BITS'(1);
        hit = 1'b0; found = 1'b0; hway = '0; vway = '0; oldest = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            lines[w] = rdata[w*LINE_BITS +: LINE_BITS];
            if (!r_set_init[r_req.set_index]) lines[w].valid = 1'b0;
            if (!r_set_init[r_req.set_index]) lines[w].dirty = 1'b0;
        end
        for (int w = MAX_WAYS-1; w >= 0; w--) begin
            if ((WCNT_BITS+1)'(w) < ways) begin
                if (lines[w].valid && lines[w].tag == r_req.tag) begin
                    hit = 1'b1; hway = WAY_BITS'(w);
                end
                if (!lines[w].valid) begin
                    found = 1'b1; vway = WAY_BITS'(w);
                end
            end
        end
        if (!found) begin
            oldest = lines[0].stamp;
            for (int w = 1; w < MAX_WAYS; w++) begin
                if ((WCNT_BITS+1)'(w) < ways && lines[w].stamp < oldest) begin
                    oldest = lines[w].stamp; vway = WAY_BITS'(w);
                end
            end
        end
        way = hit ? hway : vway;
        wb  = !hit && lines[vway].valid && lines[vway].dirty;
        // updated set word
        wdata = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            t_line l;
            l = lines[w];
            if (WAY_BITS'(w) == way) begin
                if (hit) begin
                    if (i_mode == MODE_LRU) l.stamp = stamp;
                    if (r_req.is_write) l.dirty = 1'b1;
                end else begin
                    l.valid = 1'b1;
                    l.dirty = r_req.is_write;
                    l.tag   = r_req.tag;
                    l.stamp = stamp;
                end
            end
            wdata[w*LINE_BITS +: LINE_BITS] = l;
        end
    end

    // sequencer: pop and read, evaluate and write back
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        we      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && !r_ovalid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_EVAL;
            ST_EVAL: begin
                we = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_req <= i_q_req;
        if (we) begin
            r_hit  <= hit;
            r_way  <= way;
            r_wb   <= wb;
            r_vtag <= wb ? lines[vway].tag : '0;
        end
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_set_init <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) begin
                r_count <= stamp;
                r_set_init[r_req.set_index] <= 1'b1;
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_hit        = r_hit;
    assign o_way_used   = 3'(r_way);
    assign o_write_back = r_wb;
    assign o_victim_tag = r_vtag;

    a_eval_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> !r_ovalid) else $error("result overwritten");
    a_read_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_EVAL)) else $error("sequence slip");
    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_wb |-> !r_hit) else $error("write-back on hit");
endmodule
`default_nettype wire

[src/set_assoc_cache_tag_lookup.sv]
// Top level of the set-associative cache tag lookup.
// Depends on sact_pkg, sact_front, sact_back, sact_ram.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_func, i_set_index, i_addr_tag
//   result    out        o_valid / i_stall    o_hit, o_way_used, o_write_back,
//                                             o_victim_tag
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Each beat passes through the back-end steps in order: queue pop issuing the
// set read, set read data, then compare with set write and result register
// load. The next pop waits until the result beat of the last one has left.
// Synchronous active-low reset; no clearing pass (per-set valid flags).
// A two-entry queue lets requests arrive while a result is stalled.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_tag_lookup
    import sact_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_func,
    input  wire logic [5:0]               i_set_index,
    input  wire logic [TAG_BITS-1:0]      i_addr_tag,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_hit,
    output logic [2:0]                    o_way_used,
    output logic                          o_write_back,
    output logic [TAG_BITS-1:0]           o_victim_tag
);
    logic                 r_mode;
    logic [WCNT_BITS-1:0] r_ways;
    logic q_valid, q_pop;
    t_req q_req;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_ways <= WCNT_BITS'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_REPLACE_MODE: r_mode <= i_cfg_data[0];
                REG_WAYS_IN_USE:  r_ways <= i_cfg_data[WCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    sact_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_set_index(i_set_index), .i_addr_tag(i_addr_tag),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_req(q_req)
    );

    sact_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_mode(r_mode), .i_ways(r_ways),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_req(q_req),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hit(o_hit), .o_way_used(o_way_used),
        .o_write_back(o_write_back), .o_victim_tag(o_victim_tag)
    );
endmodule
`default_nettype wire

[bench/sact_lookup_checker.sv]
// Checker for the set-associative cache tag lookup: watches the request and
// result channels, predicts each result from its own copy of the tag state.
// Depends on sact_pkg.
`timescale 1ns / 1ps
module sact_lookup_checker
    import sact_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    input  logic                     i_stall_req,
    input  logic                     i_func,
    input  logic [5:0]               i_set_index,
    input  logic [TAG_BITS-1:0]      i_addr_tag,
    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic                     i_hit,
    input  logic [2:0]               i_way_used,
    input  logic                     i_write_back,
    input  logic [TAG_BITS-1:0]      i_victim_tag,
    output int                       o_errors,
    output int                       o_pending,
    output logic                     o_beat_seen
);
    typedef struct packed {
        logic                hit;
        logic [2:0]          way;
        logic                wb;
        logic [TAG_BITS-1:0] vtag;
    } t_outcome;

    // shadow tag store
    logic                  sh_valid [NUM_SETS][MAX_WAYS];
    logic                  sh_dirty [NUM_SETS][MAX_WAYS];
    logic [TAG_BITS-1:0]   sh_tag   [NUM_SETS][MAX_WAYS];
    logic [STAMP_BITS-1:0] sh_stamp [NUM_SETS][MAX_WAYS];
    logic [STAMP_BITS-1:0] sh_count;
    logic                  sh_mode;
    logic [3:0]            sh_ways;

    t_outcome outcome_q[$];

    function automatic t_outcome lookup_and_fill(logic wr, logic [5:0] s,
                                                 logic [TAG_BITS-1:0] tg);
        t_outcome r;
        int n, v;
        bit found;
        logic [STAMP_BITS-1:0] oldest;
        n = (sh_ways < 1) ? 1 : (sh_ways > MAX_WAYS) ? MAX_WAYS : sh_ways;
        r = '0;
        sh_count = sh_count + 1;
        for (int w = 0; w < n; w++) begin
            if (sh_valid[s][w] && sh_tag[s][w] == tg) begin
                if (sh_mode == MODE_LRU) sh_stamp[s][w] = sh_count;
                if (wr == FUNC_WRITE) sh_dirty[s][w] = 1'b1;
                r.hit = 1'b1;
                r.way = w[2:0];
                return r;
            end
        end
        found = 0;
        v = 0;
        for (int w = 0; w < n; w++) begin
            if (!found && !sh_valid[s][w]) begin
                v = w;
                found = 1;
            end
        end
        if (!found) begin
            oldest = sh_stamp[s][0];
            for (int w = 1; w < n; w++) begin
                if (sh_stamp[s][w] < oldest) begin
                    oldest = sh_stamp[s][w];
                    v = w;
                end
            end
        end
        if (sh_valid[s][v] && sh_dirty[s][v]) begin
            r.wb = 1'b1;
            r.vtag = sh_tag[s][v];
        end
        sh_tag[s][v] = tg;
        sh_stamp[s][v] = sh_count;
        sh_valid[s][v] = 1'b1;
        sh_dirty[s][v] = (wr == FUNC_WRITE);
        r.way = v[2:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome got, exp_r;
        logic seen;
        seen = 1'b0;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++)
                for (int w = 0; w < MAX_WAYS; w++) begin
                    sh_valid[s][w] = 1'b0;
                    sh_dirty[s][w] = 1'b0;
                    sh_tag[s][w] = '0;
                    sh_stamp[s][w] = '0;
                end
            sh_count = '0;
            sh_mode = MODE_LRU;
            sh_ways = 4'd8;
            outcome_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_REPLACE_MODE) sh_mode = i_cfg_data[0];
                else if (i_cfg_index == REG_WAYS_IN_USE) sh_ways = i_cfg_data;
            end
            // result beat is checked before the request of the same edge
            if (i_res_valid && !i_res_stall) begin
                seen = 1'b1;
                got = '{i_hit, i_way_used, i_write_back, i_victim_tag};
                if (outcome_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result beat: %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = outcome_q.pop_front();
                    if (got !== exp_r) begin
                        if (o_errors < 10)
                            $display("mismatch: exp %p got %p", exp_r, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && !i_stall_req) begin
                seen = 1'b1;
                outcome_q.push_back(lookup_and_fill(i_func, i_set_index, i_addr_tag));
            end
            o_pending <= outcome_q.size();
        end
        o_beat_seen <= seen;
    end
endmodule

[bench/tb_set_assoc_cache_tag_lookup.sv]
// Testbench top for the set-associative cache tag lookup: makes request
// stimulus, config phases and stalls. Depends on sact_pkg, the block, the checker.
`timescale 1ns / 1ps
module tb_set_assoc_cache_tag_lookup;
    import sact_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_func = 1'b0;
    logic [5:0]               i_set_index = '0;
    logic [TAG_BITS-1:0]      i_addr_tag = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic                     o_hit;
    logic [2:0]               o_way_used;
    logic                     o_write_back;
    logic [TAG_BITS-1:0]      o_victim_tag;
    int                       errors, pending;
    logic                     beat_seen;
    int                       send_idle_pct = 0;
    int                       recv_stall_pct = 0;
    int                       quiet_cycles = 0;
    logic [TAG_BITS-1:0]      tag_pool [16];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    set_assoc_cache_tag_lookup dut (.*);

    sact_lookup_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_stall_req(o_stall), .i_func, .i_set_index, .i_addr_tag,
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_hit(o_hit),
        .i_way_used(o_way_used),
        .i_write_back(o_write_back), .i_victim_tag(o_victim_tag),
        .o_errors(errors), .o_pending(pending), .o_beat_seen(beat_seen)
    );

    // random receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (beat_seen || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb_set_assoc_cache_tag_lookup: errors");
            $finish;
        end
    end

    // one request beat, holding until accepted; stall is sampled mid-cycle
    task automatic send_access(logic wr, logic [5:0] s, logic [TAG_BITS-1:0] tg);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= wr;
        i_set_index <= s;
        i_addr_tag <= tg;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain_all();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly reuse a small tag pool on a few sets to get hits and evictions
    task automatic random_burst(int n);
        logic [TAG_BITS-1:0] tg;
        logic [5:0] s;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 8) begin
                tg = tag_pool[$urandom_range(15)];
                s = 6'($urandom_range(3));
            end else begin
                tg = TAG_BITS'($urandom);
                s = 6'($urandom);
            end
            send_access(1'($urandom_range(1)), s, tg);
            if (k == n / 2 && n > 100) drain_all();
        end
    endtask

    initial begin
        int ph;
        logic [3:0] ways_set [6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        for (int i = 0; i < 16; i++) tag_pool[i] = TAG_BITS'($urandom);
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, fill of a whole set, dirty eviction, hits
        send_access(1'b0, 6'd0, '0);
        send_access(1'b1, 6'd63, '1);
        send_access(1'b1, 6'd0, '0);
        send_access(1'b0, 6'd63, '1);
        for (int w = 0; w < 9; w++) send_access(1'b1, 6'd5, TAG_BITS'(20'h100 + w));
        send_access(1'b0, 6'd5, 20'h102);
        send_access(1'b1, 6'd5, 20'h103);
        for (int w = 0; w < 4; w++) send_access(1'b0, 6'd5, TAG_BITS'(20'h200 + w));
        drain_all();

        // config phases across modes, way counts, idling and stalls
        for (ph = 0; ph < 12; ph++) begin
            write_reg(REG_REPLACE_MODE, CFG_DATA_BITS'(ph[0]));
            write_reg(REG_WAYS_IN_USE, ways_set[ph % 6]);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 87; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 87; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            random_burst(90);
            drain_all();
        end
        recv_stall_pct = 0;
        drain_all();
        if (errors == 0) $display("tb_set_assoc_cache_tag_lookup: clean");
        else $display("tb_set_assoc_cache_tag_lookup: errors");
        $finish;
    end
endmodule

[set_assoc_cache_tag_lookup.f]
src/sact_pkg.sv
src/sact_ram.sv
src/sact_front.sv
src/sact_back.sv
src/set_assoc_cache_tag_lookup.sv
bench/sact_lookup_checker.sv
bench/tb_set_assoc_cache_tag_lookup.sv
